// File: hw/rtl/clcd_pkg.sv
package clcd_pkg;

  typedef enum logic [2:0] {
    OP_CMD    = 3'd0,
    OP_CHAR   = 3'd1,
    OP_CURSOR = 3'd2,
    OP_INIT   = 3'd3,
    OP_NUMBER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_NIBBLE = 2'd0,
    KIND_BUSY   = 2'd1,
    KIND_WAIT   = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [4:0] pc_t;

  // Micro-operation of one control word.
  typedef enum logic {
    UOP_EMIT,
    UOP_DIGIT
  } uop_t;

  typedef enum logic [1:0] {
    NSEL_CONST,
    NSEL_HI,
    NSEL_LO
  } nsel_t;

  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_ONE,
    RSEL_REQ
  } rsel_t;

  typedef enum logic [1:0] {
    WSEL_NONE,
    WSEL_POWER,
    WSEL_SHORT
  } wsel_t;

  typedef enum logic [1:0] {
    FIN_NO,
    FIN_END,
    FIN_LOOP
  } fin_t;

  typedef struct packed {
    uop_t       uop;
    kind_t      kind;
    nsel_t      nsel;
    rsel_t      rsel;
    wsel_t      wsel;
    logic [3:0] cnib;
    fin_t       fin;
  } uword_t;

  localparam logic [7:0]  CURSOR_ROW0   = 8'h80;
  localparam logic [7:0]  CURSOR_ROW1   = 8'hC0;
  localparam logic [7:0]  CHAR_ZERO     = 8'h30;
  localparam logic [13:0] WAIT_POWER_US = 14'd16000;
  localparam logic [13:0] WAIT_SHORT_US = 14'd50;

  // Program entry points and landmarks.
  localparam pc_t PC_BYTE   = 5'd0;
  localparam pc_t PC_NUMBER = 5'd3;
  localparam pc_t PC_DIGIT  = 5'd6;
  localparam pc_t PC_INIT   = 5'd10;
  localparam pc_t PC_LAST   = 5'd25;

  function automatic uword_t uc_emit(input kind_t k, input nsel_t ns, input rsel_t rs,
                                     input wsel_t ws, input logic [3:0] cn, input fin_t f);
    uword_t w;
    w.uop  = UOP_EMIT;
    w.kind = k;
    w.nsel = ns;
    w.rsel = rs;
    w.wsel = ws;
    w.cnib = cn;
    w.fin  = f;
    return w;
  endfunction

  function automatic uword_t uc_nib(input logic [3:0] cn);
    return uc_emit(KIND_NIBBLE, NSEL_CONST, RSEL_ZERO, WSEL_NONE, cn, FIN_NO);
  endfunction

  function automatic uword_t uc_busy(input fin_t f);
    return uc_emit(KIND_BUSY, NSEL_CONST, RSEL_ZERO, WSEL_NONE, 4'h0, f);
  endfunction

  function automatic uword_t uc_wait(input wsel_t ws);
    return uc_emit(KIND_WAIT, NSEL_CONST, RSEL_ZERO, ws, 4'h0, FIN_NO);
  endfunction

  // The sequencer program. A byte is always high nibble, low nibble, busy wait.
  function automatic uword_t clcd_ucode(input pc_t pc);
    uword_t w;
    w = uc_busy(FIN_END);
    unique case (pc)
      // Command, character or cursor byte.
      5'd0:  w = uc_emit(KIND_NIBBLE, NSEL_HI, RSEL_REQ, WSEL_NONE, 4'h0, FIN_NO);
      5'd1:  w = uc_emit(KIND_NIBBLE, NSEL_LO, RSEL_REQ, WSEL_NONE, 4'h0, FIN_NO);
      5'd2:  w = uc_busy(FIN_END);
      // Number: cursor byte, then one byte per digit.
      5'd3:  w = uc_emit(KIND_NIBBLE, NSEL_HI, RSEL_ZERO, WSEL_NONE, 4'h0, FIN_NO);
      5'd4:  w = uc_emit(KIND_NIBBLE, NSEL_LO, RSEL_ZERO, WSEL_NONE, 4'h0, FIN_NO);
      5'd5:  w = uc_busy(FIN_NO);
      5'd6:  begin
        w     = uc_busy(FIN_NO);
        w.uop = UOP_DIGIT;
      end
      5'd7:  w = uc_emit(KIND_NIBBLE, NSEL_HI, RSEL_ONE, WSEL_NONE, 4'h0, FIN_NO);
      5'd8:  w = uc_emit(KIND_NIBBLE, NSEL_LO, RSEL_ONE, WSEL_NONE, 4'h0, FIN_NO);
      5'd9:  w = uc_busy(FIN_LOOP);
      // Power-up sequence.
      5'd10: w = uc_wait(WSEL_POWER);
      5'd11: w = uc_nib(4'h3);
      5'd12: w = uc_wait(WSEL_SHORT);
      5'd13: w = uc_nib(4'h3);
      5'd14: w = uc_wait(WSEL_SHORT);
      5'd15: w = uc_nib(4'h2);
      5'd16: w = uc_busy(FIN_NO);
      5'd17: w = uc_nib(4'h2);
      5'd18: w = uc_nib(4'h8);
      5'd19: w = uc_busy(FIN_NO);
      5'd20: w = uc_nib(4'h0);
      5'd21: w = uc_nib(4'hC);
      5'd22: w = uc_busy(FIN_NO);
      5'd23: w = uc_nib(4'h0);
      5'd24: w = uc_nib(4'h1);
      5'd25: w = uc_busy(FIN_END);
      default: w = uc_busy(FIN_END);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/clcd_req_if.sv
interface clcd_req_if
  import clcd_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] value;
  logic        row;
  logic [5:0]  column;
  logic [2:0]  digit_count;

  modport source (output valid, op, value, row, column, digit_count, input ready);
  modport sink (input valid, op, value, row, column, digit_count, output ready);
endinterface

// File: hw/rtl/clcd_step_if.sv
interface clcd_step_if
  import clcd_pkg::*;
();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [13:0] wait_us;
  logic        last;

  modport source (output valid, kind, reg_select, nibble, wait_us, last, input ready);
  modport sink (input valid, kind, reg_select, nibble, wait_us, last, output ready);
endinterface

// File: hw/rtl/clcd_digits.sv
module clcd_digits
  import clcd_pkg::*;
#(
  parameter int MAX_DIGITS = 5,
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [15:0]   value,
  input  logic [CW-1:0] count,
  input  logic [IW-1:0] rd_idx,
  output logic          busy,
  output logic [3:0]    digit
);

  logic [15:0]   v_r;
  logic [IW-1:0] wi_r;
  logic [CW-1:0] left_r;
  logic [3:0]    d_r [MAX_DIGITS];
  logic [32:0]   prod;
  logic [15:0]   quo;
  logic [15:0]   rem;

  // Division by ten as a multiply by the rounded reciprocal; exact for 16-bit values.
  assign prod = v_r * 17'd52429;
  assign quo  = 16'(prod[32:19]);
  assign rem  = v_r - ((quo << 3) + (quo << 1));

  assign busy  = (left_r != '0);
  assign digit = d_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (start) begin
      left_r <= count;
    end else if (busy) begin
      left_r <= left_r - CW'(1);
    end
  end

  // Digits come out least significant first and are stored most significant at index 0.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r  <= value;
      wi_r <= IW'(count - CW'(1));
    end else if (busy) begin
      d_r[wi_r] <= rem[3:0];
      v_r       <= quo;
      wi_r      <= wi_r - IW'(1);
    end
  end

endmodule

// File: hw/rtl/char_lcd_4bit_write_sequencer_unit.sv
// Character LCD 4-bit write sequencer: each named op on in_req becomes a run of bus steps on
// out_step (nibble write with enable pulse, busy-flag wait, or timed wait), the final step
// carrying last. Command and character requests give three steps, a cursor request three,
// the power-up request sixteen, and a number request three plus three per digit. A
// microcoded sequencer with a program counter walks a small control store and issues at
// most one step per clock; each printed digit also takes a control word of its own that
// loads its character. The decimal split starts when a number request is taken and
// yields one digit per clock, so it hides behind the three cursor steps for up to three
// digits; a fourth and a fifth digit each hold the first character load back further. A
// new request is taken once the final step has been loaded into the output register.
module char_lcd_4bit_write_sequencer_unit
  import clcd_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  clcd_req_if.sink    in_req,
  clcd_step_if.source out_step
);

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t        state_r, state_nxt;
  pc_t           pc_r, pc_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          rs_r, rs_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] ri_r, ri_nxt;
  logic          out_valid_r, out_valid_nxt;

  kind_t         kind_r;
  logic          reg_select_r;
  logic [3:0]    nibble_r;
  logic [13:0]   wait_us_r;
  logic          last_r;

  uword_t        uw;
  logic          emit;
  logic          step_last;
  logic [3:0]    step_nib;
  logic          step_rs;
  logic [13:0]   step_wait;
  logic [7:0]    cursor_byte;
  logic [CW-1:0] n_sat;
  logic          dig_start;
  logic          dig_busy;
  logic [3:0]    dig_value;

  assign uw          = clcd_ucode(pc_r);
  assign cursor_byte = (in_req.row ? CURSOR_ROW1 : CURSOR_ROW0) + {2'b00, in_req.column};

  always_comb begin
    if (in_req.digit_count == 3'd0) begin
      n_sat = CW'(1);
    end else if (in_req.digit_count > 3'(MAX_DIGITS)) begin
      n_sat = CW'(MAX_DIGITS);
    end else begin
      n_sat = CW'(in_req.digit_count);
    end
  end

  clcd_digits #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dig_start),
    .value (in_req.value),
    .count (n_sat),
    .rd_idx(ri_r[IW-1:0]),
    .busy  (dig_busy),
    .digit (dig_value)
  );

  // Datapath selections driven by the current control word.
  always_comb begin
    unique case (uw.nsel)
      NSEL_HI: step_nib = byte_r[7:4];
      NSEL_LO: step_nib = byte_r[3:0];
      default: step_nib = uw.cnib;
    endcase
    unique case (uw.rsel)
      RSEL_ONE: step_rs = 1'b1;
      RSEL_REQ: step_rs = rs_r;
      default:  step_rs = 1'b0;
    endcase
    unique case (uw.wsel)
      WSEL_POWER: step_wait = WAIT_POWER_US;
      WSEL_SHORT: step_wait = WAIT_SHORT_US;
      default:    step_wait = 14'd0;
    endcase
    unique case (uw.fin)
      FIN_END:  step_last = 1'b1;
      FIN_LOOP: step_last = (ri_r == n_r);
      default:  step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    byte_nxt      = byte_r;
    rs_nxt        = rs_r;
    n_nxt         = n_r;
    ri_nxt        = ri_r;
    out_valid_nxt = out_valid_r && !out_step.ready;
    in_req.ready  = 1'b0;
    dig_start     = 1'b0;
    emit          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          unique case (in_req.op)
            OP_CMD, OP_CHAR: begin
              byte_nxt  = in_req.value[7:0];
              rs_nxt    = (in_req.op == OP_CHAR);
              pc_nxt    = PC_BYTE;
              state_nxt = ST_RUN;
            end
            OP_CURSOR: begin
              byte_nxt  = cursor_byte;
              rs_nxt    = 1'b0;
              pc_nxt    = PC_BYTE;
              state_nxt = ST_RUN;
            end
            OP_INIT: begin
              pc_nxt    = PC_INIT;
              state_nxt = ST_RUN;
            end
            OP_NUMBER: begin
              byte_nxt  = cursor_byte;
              n_nxt     = n_sat;
              ri_nxt    = '0;
              dig_start = 1'b1;
              pc_nxt    = PC_NUMBER;
              state_nxt = ST_RUN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        unique case (uw.uop)
          UOP_DIGIT: begin
            if (!dig_busy) begin
              byte_nxt = CHAR_ZERO + {4'h0, dig_value};
              ri_nxt   = ri_r + CW'(1);
              pc_nxt   = pc_r + 5'd1;
            end
          end
          default: begin
            if (!out_valid_r || out_step.ready) begin
              emit          = 1'b1;
              out_valid_nxt = 1'b1;
              if (step_last) begin
                state_nxt = ST_IDLE;
              end else if (uw.fin == FIN_LOOP) begin
                pc_nxt = PC_DIGIT;
              end else begin
                pc_nxt = pc_r + 5'd1;
              end
            end
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_BYTE;
      n_r         <= CW'(1);
      ri_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      n_r         <= n_nxt;
      ri_r        <= ri_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
    if (emit) begin
      kind_r       <= uw.kind;
      reg_select_r <= step_rs;
      nibble_r     <= step_nib;
      wait_us_r    <= step_wait;
      last_r       <= step_last;
    end
  end

  assign out_step.valid      = out_valid_r;
  assign out_step.kind       = kind_r;
  assign out_step.reg_select = reg_select_r;
  assign out_step.nibble     = nibble_r;
  assign out_step.wait_us    = wait_us_r;
  assign out_step.last       = last_r;

`ifndef SYNTH
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> pc_r <= PC_LAST)
    else $error("program counter ran past the end of the control store");

  a_digit_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && pc_r >= PC_DIGIT && pc_r < PC_INIT |-> ri_r <= n_r)
    else $error("digit index passed the digit count");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit && step_last |=> state_r == ST_IDLE && out_step.valid && out_step.last)
    else $error("final step did not end the run");

  a_digit_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && uw.uop == UOP_DIGIT && !dig_busy |=> ri_r == $past(ri_r) + CW'(1))
    else $error("digit load did not advance the digit index");
`endif

endmodule

// File: bench/char_lcd_4bit_write_sequencer_unit_test.sv
module char_lcd_4bit_write_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam int MAX_DIGITS      = 5;
  localparam int RANDOM_REQUESTS = 260;
  localparam int IDLE_PERCENT    = 35;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PRINT_CAP       = 100;

  // Op codes that the package leaves unnamed; the block must ignore them.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

  typedef struct packed {
    kind_t       kind;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [13:0] wait_us;
    logic        last;
  } lcd_step_t;

  // One request as offered; typed rows carry a hand-written single-byte answer, unused for spare ops.
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] value;
    logic        row;
    logic [5:0]  column;
    logic [2:0]  digits;
    logic        typed;
    logic [7:0]  typed_byte;
    logic        typed_rs;
  } lcd_request_t;

  logic clk;
  logic rst_n;
  logic steady;
  int   cycles;
  int   error_count;
  int   step_count;

  lcd_step_t    run_steps[$];
  lcd_step_t    expected_steps[$];
  lcd_request_t offered_requests[$];
  lcd_request_t directed_table[$];

  clcd_req_if  req_if ();
  clcd_step_if step_if ();

  char_lcd_4bit_write_sequencer_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_step(step_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("mismatch at cycle %0d, step %0d: %s", cycles, step_count, msg);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void add_step(input kind_t k, input logic rs, input logic [3:0] nib,
                                   input logic [13:0] us);
    lcd_step_t s;
    s.kind       = k;
    s.reg_select = rs;
    s.nibble     = nib;
    s.wait_us    = us;
    s.last       = 1'b0;
    run_steps.push_back(s);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic rs);
    add_step(KIND_NIBBLE, rs, b[7:4], 14'd0);
    add_step(KIND_NIBBLE, rs, b[3:0], 14'd0);
    add_step(KIND_BUSY, 1'b0, 4'h0, 14'd0);
  endfunction

  function automatic logic [7:0] cursor_address(input logic row, input logic [5:0] column);
    return (row ? CURSOR_ROW1 : CURSOR_ROW0) + {2'b00, column};
  endfunction

  // Moves the steps of one request to the expected queue, marking the final one.
  function automatic void close_run();
    lcd_step_t s;
    for (int i = 0; i < run_steps.size(); i++) begin
      s      = run_steps[i];
      s.last = (i == run_steps.size() - 1);
      expected_steps.push_back(s);
    end
    run_steps.delete();
  endfunction

  function automatic void predict_bus_steps(input logic [2:0] op, input logic [15:0] value,
                                            input logic row, input logic [5:0] column,
                                            input logic [2:0] digits);
    int         n;
    int         v;
    logic [3:0] digit_val[MAX_DIGITS];
    case (op)
      OP_CMD:    add_byte(value[7:0], 1'b0);
      OP_CHAR:   add_byte(value[7:0], 1'b1);
      OP_CURSOR: add_byte(cursor_address(row, column), 1'b0);
      OP_INIT: begin
        add_step(KIND_WAIT, 1'b0, 4'h0, WAIT_POWER_US);
        add_step(KIND_NIBBLE, 1'b0, NIB_WAKE, 14'd0);
        add_step(KIND_WAIT, 1'b0, 4'h0, WAIT_SHORT_US);
        add_step(KIND_NIBBLE, 1'b0, NIB_WAKE, 14'd0);
        add_step(KIND_WAIT, 1'b0, 4'h0, WAIT_SHORT_US);
        add_step(KIND_NIBBLE, 1'b0, NIB_FOUR_BIT, 14'd0);
        add_step(KIND_BUSY, 1'b0, 4'h0, 14'd0);
        add_byte(CMD_FUNCTION_SET, 1'b0);
        add_byte(CMD_DISPLAY_ON, 1'b0);
        add_byte(CMD_CLEAR, 1'b0);
      end
      OP_NUMBER: begin
        n = int'(digits);
        if (n == 0) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        v = int'(value);
        // Least significant digit first; whatever is left over in v is dropped.
        for (int i = n - 1; i >= 0; i--) begin
          digit_val[i] = 4'(v % 10);
          v = v / 10;
        end
        add_byte(cursor_address(row, column), 1'b0);
        for (int i = 0; i < n; i++) begin
          add_byte(CHAR_ZERO + {4'h0, digit_val[i]}, 1'b1);
        end
      end
      default: ;
    endcase
    close_run();
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [15:0] value,
                                  input logic row, input logic [5:0] column,
                                  input logic [2:0] digits, input logic typed,
                                  input logic [7:0] typed_byte, input logic typed_rs);
    lcd_request_t r;
    r.op         = op;
    r.value      = value;
    r.row        = row;
    r.column     = column;
    r.digits     = digits;
    r.typed      = typed;
    r.typed_byte = typed_byte;
    r.typed_rs   = typed_rs;
    directed_table.push_back(r);
  endfunction

  task automatic send_request(input lcd_request_t r);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    offered_requests.push_back(r);
    req_if.valid       <= 1'b1;
    req_if.op          <= r.op;
    req_if.value       <= r.value;
    req_if.row         <= r.row;
    req_if.column      <= r.column;
    req_if.digit_count <= r.digits;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Both handshakes are sampled here, so a request is predicted before its steps return.
  always @(posedge clk) begin : step_monitor
    lcd_request_t r;
    lcd_step_t    want;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        if (offered_requests.size() == 0) begin
          report_mismatch("request accepted that was never offered");
        end else begin
          r = offered_requests.pop_front();
          if (r.typed) begin
            if (r.op <= OP_NUMBER) add_byte(r.typed_byte, r.typed_rs);
            close_run();
          end else begin
            predict_bus_steps(req_if.op, req_if.value, req_if.row, req_if.column,
                              req_if.digit_count);
          end
        end
      end
      if (step_if.valid && step_if.ready) begin
        step_count++;
        if (expected_steps.size() == 0) begin
          report_mismatch("bus step with none expected");
        end else begin
          want = expected_steps.pop_front();
          check_field("kind", int'(step_if.kind), int'(want.kind));
          check_field("reg_select", int'(step_if.reg_select), int'(want.reg_select));
          check_field("nibble", int'(step_if.nibble), int'(want.nibble));
          check_field("wait_us", int'(step_if.wait_us), int'(want.wait_us));
          check_field("last", int'(step_if.last), int'(want.last));
        end
      end
    end
  end

  initial begin
    step_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      step_if.ready <= !rst_n ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    lcd_request_t r;
    int           useful;
    int           pick;
    int           waited;

    error_count        = 0;
    step_count         = 0;
    steady             = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_CMD;
    req_if.value       = 16'h0000;
    req_if.row         = 1'b0;
    req_if.column      = 6'd0;
    req_if.digit_count = 3'd1;

    //      op          value     row   col    digits typed  byte   rs
    add_row(OP_CMD,     16'h0000, 1'b0, 6'd0,  3'd1,  1'b1,  8'h00, 1'b0);
    add_row(OP_CMD,     16'h00FF, 1'b0, 6'd0,  3'd1,  1'b1,  8'hFF, 1'b0);
    add_row(OP_CMD,     16'hFFFF, 1'b1, 6'd63, 3'd7,  1'b1,  8'hFF, 1'b0);
    add_row(OP_CMD,     16'h1234, 1'b0, 6'd0,  3'd1,  1'b1,  8'h34, 1'b0);
    add_row(OP_CHAR,    16'h0041, 1'b0, 6'd0,  3'd1,  1'b1,  8'h41, 1'b1);
    add_row(OP_CHAR,    16'hFF00, 1'b0, 6'd0,  3'd1,  1'b1,  8'h00, 1'b1);
    add_row(OP_CHAR,    16'h00A5, 1'b0, 6'd0,  3'd1,  1'b0,  8'h00, 1'b0);
    add_row(OP_CURSOR,  16'h0000, 1'b0, 6'd0,  3'd1,  1'b1,  8'h80, 1'b0);
    add_row(OP_CURSOR,  16'hFFFF, 1'b1, 6'd0,  3'd1,  1'b1,  8'hC0, 1'b0);
    add_row(OP_CURSOR,  16'h0000, 1'b0, 6'd39, 3'd1,  1'b1,  8'hA7, 1'b0);
    add_row(OP_CURSOR,  16'h0000, 1'b1, 6'd63, 3'd1,  1'b1,  8'hFF, 1'b0);
    add_row(OP_CURSOR,  16'h0000, 1'b0, 6'd63, 3'd1,  1'b1,  8'hBF, 1'b0);
    add_row(OP_INIT,    16'h0000, 1'b0, 6'd0,  3'd1,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd0,    1'b0, 6'd0,  3'd1,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd65535, 1'b1, 6'd39, 3'd5, 1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd65535, 1'b0, 6'd4, 3'd2,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd12345, 1'b0, 6'd1, 3'd0,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd54321, 1'b1, 6'd2, 3'd7,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd99,   1'b0, 6'd10, 3'd6,  1'b0,  8'h00, 1'b0);
    add_row(OP_NUMBER,  16'd10000, 1'b1, 6'd63, 3'd5, 1'b0,  8'h00, 1'b0);
    add_row(OP_SPARE_A, 16'h0041, 1'b0, 6'd0,  3'd1,  1'b1,  8'h00, 1'b0);
    add_row(OP_SPARE_B, 16'hFFFF, 1'b1, 6'd63, 3'd5,  1'b1,  8'h00, 1'b0);
    add_row(OP_SPARE_C, 16'h5A5A, 1'b1, 6'd21, 3'd7,  1'b1,  8'h00, 1'b0);
    add_row(OP_INIT,    16'hFFFF, 1'b1, 6'd63, 3'd7,  1'b0,  8'h00, 1'b0);
    add_row(OP_CHAR,    16'h0030, 1'b0, 6'd0,  3'd1,  1'b1,  8'h30, 1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_table[i]) send_request(directed_table[i]);

    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      // A middle stretch runs with neither side idling.
      steady <= (useful >= 120 && useful < 200);
      pick = $urandom_range(99);
      if (pick < 8) r.op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
      else if (pick < 30) r.op = OP_CMD;
      else if (pick < 52) r.op = OP_CHAR;
      else if (pick < 68) r.op = OP_CURSOR;
      else if (pick < 74) r.op = OP_INIT;
      else r.op = OP_NUMBER;
      case ($urandom_range(3))
        0: r.value = 16'($urandom);
        1: r.value = 16'($urandom_range(99));
        2: r.value = 16'($urandom_range(9999));
        default: r.value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      r.row        = 1'($urandom_range(1));
      r.column     = 6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(39));
      r.digits     = 3'(($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(5, 1));
      r.typed      = 1'b0;
      r.typed_byte = 8'h00;
      r.typed_rs   = 1'b0;
      send_request(r);
      if (r.op <= OP_NUMBER) useful++;
    end
    req_if.valid <= 1'b0;
    steady       <= 1'b0;

    waited = 0;
    while ((expected_steps.size() != 0 || offered_requests.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_steps.size() != 0) begin
      report_mismatch($sformatf("%0d expected steps never arrived", expected_steps.size()));
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
